@@ design/ggpc_pkg.sv @@
// Shared types, constants and helper functions of the go-to-goal controller.
package ggpc_pkg;

    localparam int ATAN_ENTRIES = 24;
    localparam int ITER_W       = 5;
    localparam int OFF_W        = 17;
    localparam int XY_W         = 34;
    localparam int ANG_W        = 36;
    localparam int LIN_W        = 35;
    localparam int INVK_W       = 30;
    localparam int CFG_IDX_W    = 8;

    localparam logic signed [ANG_W-1:0] PI_Q30      = 36'sd3373259426;
    localparam logic signed [ANG_W-1:0] HALF_PI_Q30 = 36'sd1686629713;
    localparam logic [INVK_W-1:0]       INV_K_Q30   = 30'd652032874;

    localparam logic [CFG_IDX_W-1:0] CFG_GOAL_X       = 8'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_GOAL_Y       = 8'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_ARRIVE_THR   = 8'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_LINEAR_GAIN  = 8'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_ANGULAR_GAIN = 8'd4;

    typedef struct packed {
        logic signed [15:0] pos_x;
        logic signed [15:0] pos_y;
        logic signed [15:0] heading;
    } t_in;

    typedef struct packed {
        logic signed [15:0] linear_cmd;
        logic signed [15:0] angular_cmd;
        logic               arrived;
    } t_out;

    typedef struct packed {
        logic              load;
        logic              init;
        logic              iter;
        logic [ITER_W-1:0] idx;
        logic              mul_lo;
        logic              mul_hi;
        logic              combine;
        logic              gain;
        logic              out_load;
        logic              zero_out;
    } t_cmd;

    typedef struct packed {
        logic at_goal;
    } t_sts;

    function automatic logic [30:0] atan_q30(input logic [ITER_W-1:0] idx);
        logic [30:0] v;
        case (idx)
            5'd0:    v = 31'd843314856;
            5'd1:    v = 31'd497837829;
            5'd2:    v = 31'd263043836;
            5'd3:    v = 31'd133525158;
            5'd4:    v = 31'd67021686;
            5'd5:    v = 31'd33543515;
            5'd6:    v = 31'd16775850;
            5'd7:    v = 31'd8388437;
            5'd8:    v = 31'd4194282;
            5'd9:    v = 31'd2097149;
            5'd10:   v = 31'd1048575;
            5'd11:   v = 31'd524287;
            5'd12:   v = 31'd262143;
            5'd13:   v = 31'd131071;
            5'd14:   v = 31'd65535;
            5'd15:   v = 31'd32767;
            5'd16:   v = 31'd16383;
            5'd17:   v = 31'd8191;
            5'd18:   v = 31'd4095;
            5'd19:   v = 31'd2047;
            5'd20:   v = 31'd1023;
            5'd21:   v = 31'd511;
            5'd22:   v = 31'd255;
            5'd23:   v = 31'd127;
            default: v = 31'd0;
        endcase
        return v;
    endfunction

    function automatic logic signed [15:0] sat16(input logic signed [63:0] v);
        logic signed [15:0] r;
        if (v > 64'sd32767) begin
            r = 16'sh7FFF;
        end else if (v < -64'sd32768) begin
            r = 16'sh8000;
        end else begin
            r = v[15:0];
        end
        return r;
    endfunction

endpackage

@@ design/ggpc_dp.sv @@
// Datapath: configuration registers, dual iterative CORDIC, projection scaling and output register.
module ggpc_dp
    import ggpc_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_valid,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [15:0]          i_cfg_data,
    input  t_in                  i_in,
    input  t_cmd                 i_cmd,
    output t_sts                 o_sts,
    output t_out                 o_out
);

    logic signed [15:0] r_goal_x;
    logic signed [15:0] r_goal_y;
    logic [14:0]        r_thr;
    logic [15:0]        r_lin_gain;
    logic [15:0]        r_ang_gain;

    logic signed [OFF_W-1:0] r_dx;
    logic signed [OFF_W-1:0] r_dy;
    logic signed [ANG_W-1:0] r_h30;
    logic signed [ANG_W-1:0] r_nh;

    logic signed [XY_W-1:0]  r_vx;
    logic signed [XY_W-1:0]  r_vy;
    logic signed [ANG_W-1:0] r_vz;
    logic                    r_vzero;
    logic signed [XY_W-1:0]  r_rx;
    logic signed [XY_W-1:0]  r_ry;
    logic signed [ANG_W-1:0] r_rz;

    logic [46:0]             r_plo;
    logic signed [47:0]      r_phi;
    logic signed [ANG_W-1:0] r_alpha;
    logic signed [LIN_W-1:0] r_lin;
    logic signed [51:0]      r_lmul;
    logic signed [52:0]      r_amul;
    logic                    r_at_goal;
    t_out                    r_out;

    logic signed [ANG_W-1:0] n_h30;
    logic signed [XY_W-1:0]  n_x0;
    logic signed [XY_W-1:0]  n_y0;
    logic signed [XY_W-1:0]  n_vxs;
    logic signed [XY_W-1:0]  n_vys;
    logic signed [XY_W-1:0]  n_rxs;
    logic signed [XY_W-1:0]  n_rys;
    logic signed [ANG_W-1:0] n_atan;
    logic signed [64:0]      n_prod;
    logic signed [51:0]      n_lround;
    logic signed [52:0]      n_around;
    logic signed [51:0]      n_lsh;
    logic signed [52:0]      n_ash;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_goal_x   <= 16'sd256;
            r_goal_y   <= -16'sd256;
            r_thr      <= 15'd26;
            r_lin_gain <= 16'd3277;
            r_ang_gain <= 16'd3686;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_GOAL_X:       r_goal_x   <= i_cfg_data;
                CFG_GOAL_Y:       r_goal_y   <= i_cfg_data;
                CFG_ARRIVE_THR:   r_thr      <= i_cfg_data[14:0];
                CFG_LINEAR_GAIN:  r_lin_gain <= i_cfg_data;
                CFG_ANGULAR_GAIN: r_ang_gain <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        n_h30  = {{(ANG_W-33){i_in.heading[15]}}, i_in.heading, 17'b0};
        n_x0   = {{(XY_W-31){r_dx[OFF_W-1]}}, r_dx, 14'b0};
        n_y0   = {{(XY_W-31){r_dy[OFF_W-1]}}, r_dy, 14'b0};
        n_vxs  = r_vx >>> i_cmd.idx;
        n_vys  = r_vy >>> i_cmd.idx;
        n_rxs  = r_rx >>> i_cmd.idx;
        n_rys  = r_ry >>> i_cmd.idx;
        n_atan = {{(ANG_W-31){1'b0}}, atan_q30(i_cmd.idx)};
        n_prod = {r_phi, 17'b0} + {18'b0, r_plo};
        n_lround = r_lmul + 52'sd33554432;
        n_around = r_amul + 53'sd268435456;
        n_lsh    = n_lround >>> 26;
        n_ash    = n_around >>> 29;
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_dx  <= {r_goal_x[15], r_goal_x} - {i_in.pos_x[15], i_in.pos_x};
            r_dy  <= {r_goal_y[15], r_goal_y} - {i_in.pos_y[15], i_in.pos_y};
            r_h30 <= n_h30;
            r_nh  <= -n_h30;
        end
        if (i_cmd.init) begin
            r_vzero <= (r_dx == '0) && (r_dy == '0);
            if (r_dx[OFF_W-1]) begin
                r_vx <= -n_x0;
                r_vy <= -n_y0;
                r_vz <= r_dy[OFF_W-1] ? -PI_Q30 : PI_Q30;
            end else begin
                r_vx <= n_x0;
                r_vy <= n_y0;
                r_vz <= '0;
            end
            if (r_nh > HALF_PI_Q30) begin
                r_rx <= -n_x0;
                r_ry <= -n_y0;
                r_rz <= r_nh - PI_Q30;
            end else if (r_nh < -HALF_PI_Q30) begin
                r_rx <= -n_x0;
                r_ry <= -n_y0;
                r_rz <= r_nh + PI_Q30;
            end else begin
                r_rx <= n_x0;
                r_ry <= n_y0;
                r_rz <= r_nh;
            end
        end
        if (i_cmd.iter) begin
            if (!r_vy[XY_W-1] && (r_vy != '0)) begin
                r_vx <= r_vx + n_vys;
                r_vy <= r_vy - n_vxs;
                r_vz <= r_vz + n_atan;
            end else begin
                r_vx <= r_vx - n_vys;
                r_vy <= r_vy + n_vxs;
                r_vz <= r_vz - n_atan;
            end
            if (!r_rz[ANG_W-1]) begin
                r_rx <= r_rx - n_rys;
                r_ry <= r_ry + n_rxs;
                r_rz <= r_rz - n_atan;
            end else begin
                r_rx <= r_rx + n_rys;
                r_ry <= r_ry - n_rxs;
                r_rz <= r_rz + n_atan;
            end
        end
        if (i_cmd.mul_lo) begin
            r_plo   <= 47'(r_rx[16:0]) * 47'(INV_K_Q30);
            r_alpha <= (r_vzero ? '0 : r_vz) - r_h30;
        end
        if (i_cmd.mul_hi) begin
            r_phi <= $signed(r_rx[XY_W-1:17]) * $signed({1'b0, INV_K_Q30});
        end
        if (i_cmd.combine) begin
            r_lin <= n_prod[64:30];
        end
        if (i_cmd.gain) begin
            r_lmul    <= $signed({1'b0, r_lin_gain}) * r_lin;
            r_amul    <= $signed({1'b0, r_ang_gain}) * r_alpha;
            r_at_goal <= (r_lin <= $signed({6'b0, r_thr, 14'b0}));
        end
        if (i_cmd.out_load) begin
            if (i_cmd.zero_out) begin
                r_out.linear_cmd  <= '0;
                r_out.angular_cmd <= '0;
                r_out.arrived     <= 1'b1;
            end else begin
                r_out.linear_cmd  <= sat16({{12{n_lsh[51]}}, n_lsh});
                r_out.angular_cmd <= sat16({{11{n_ash[52]}}, n_ash});
                r_out.arrived     <= 1'b0;
            end
        end
    end

    assign o_sts.at_goal = r_at_goal;
    assign o_out         = r_out;

endmodule

@@ design/ggpc_ctrl.sv @@
// Controller: sequences one item through load, CORDIC iterations, scaling and output.
module ggpc_ctrl
    import ggpc_pkg::*;
#(
    parameter int ITERS = 16
)
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    output logic o_in_ready,
    output logic o_out_valid,
    input  logic i_out_ready,
    input  t_sts i_sts,
    output t_cmd o_cmd
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_INIT,
        S_ITER,
        S_MLO,
        S_MHI,
        S_COMB,
        S_GAIN,
        S_DONE
    } t_state;

    localparam logic [ITER_W-1:0] LAST_ITER = ITER_W'(ITERS - 1);

    t_state            r_state;
    logic [ITER_W-1:0] r_iter;
    logic              r_done;
    logic              r_out_valid;
    logic              n_accept;
    logic              n_out_free;

    always_comb begin
        n_accept       = i_in_valid && (r_state == S_IDLE);
        n_out_free     = !r_out_valid || i_out_ready;
        o_cmd          = '0;
        o_cmd.load     = n_accept;
        o_cmd.init     = (r_state == S_INIT);
        o_cmd.iter     = (r_state == S_ITER);
        o_cmd.idx      = r_iter;
        o_cmd.mul_lo   = (r_state == S_MLO);
        o_cmd.mul_hi   = (r_state == S_MHI);
        o_cmd.combine  = (r_state == S_COMB);
        o_cmd.gain     = (r_state == S_GAIN);
        o_cmd.out_load = (r_state == S_DONE) && n_out_free;
        o_cmd.zero_out = r_done || i_sts.at_goal;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_iter      <= '0;
            r_done      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_cmd.out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (n_accept) begin
                        r_state <= S_INIT;
                    end
                end
                S_INIT: begin
                    r_iter  <= '0;
                    r_state <= S_ITER;
                end
                S_ITER: begin
                    if (r_iter == LAST_ITER) begin
                        r_state <= S_MLO;
                    end else begin
                        r_iter <= r_iter + 1'b1;
                    end
                end
                S_MLO:  r_state <= S_MHI;
                S_MHI:  r_state <= S_COMB;
                S_COMB: r_state <= S_GAIN;
                S_GAIN: r_state <= S_DONE;
                S_DONE: begin
                    if (n_out_free) begin
                        if (i_sts.at_goal) begin
                            r_done <= 1'b1;
                        end
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;

    // Once the goal has been reached, only reset clears the latch.
    a_done_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |=> r_done)
        else $error("arrival latch cleared without reset");

    // A result is only written into the output register when it is free.
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.out_load |-> (!r_out_valid || i_out_ready))
        else $error("output register overwritten");

    // A loaded result is presented on the next cycle.
    a_load_shows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.out_load |=> r_out_valid)
        else $error("loaded result not presented");

    // The iteration index stays inside the arctangent table.
    a_iter_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_ITER) |-> (r_iter <= LAST_ITER))
        else $error("CORDIC iteration index out of range");

endmodule

@@ design/go_to_goal_p_controller.sv @@
// Top level of the go-to-goal proportional controller.
//
// Each item on the input channel is one pose sample (position and heading).
// For each accepted item exactly one result item leaves on the output channel:
// linear and angular commands, or zeros with arrived set once the goal is met.
// The configuration channel writes goal, arrival threshold and gains by index;
// it is always ready and should only be used while no item is in flight.
// An item occupies the block from acceptance until its result is valid; that
// time is set mainly by the shared iteration loop of the two CORDIC lanes
// (vectoring and rotation, one step per cycle).
// The next item can be accepted in the cycle after the result is loaded, so
// a new item is not taken until the last one's result has been loaded.
// A finished result waits in the output register while the receiver stalls;
// the block accepts and works on the next item meanwhile, and holds that one
// at its last step until the output register is free.
// Reset restores the default registers and clears the arrival latch.
module go_to_goal_p_controller
    import ggpc_pkg::*;
#(
    parameter int CORDIC_ITERATIONS = 16
)
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  t_in                  i_in,
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output t_out                 o_out,
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [15:0]          i_cfg_data
);

    localparam int ITERS = (CORDIC_ITERATIONS > ATAN_ENTRIES) ? ATAN_ENTRIES :
                           ((CORDIC_ITERATIONS < 1) ? 1 : CORDIC_ITERATIONS);

    t_cmd w_cmd;
    t_sts w_sts;

    assign o_cfg_ready = 1'b1;

    ggpc_ctrl #(
        .ITERS(ITERS)
    ) u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .o_out_valid(o_out_valid),
        .i_out_ready(i_out_ready),
        .i_sts      (w_sts),
        .o_cmd      (w_cmd)
    );

    ggpc_dp u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_valid(i_cfg_valid),
        .i_cfg_index(i_cfg_index),
        .i_cfg_data (i_cfg_data),
        .i_in       (i_in),
        .i_cmd      (w_cmd),
        .o_sts      (w_sts),
        .o_out      (o_out)
    );

endmodule
